// ----- rtl/tst_pkg.sv -----
// shared constants and types for the two-axis slew time engine
package tst_pkg;

   localparam int RATE_W      = 21;
   localparam int AZ_W        = 27;
   localparam int EL_W        = 25;
   localparam int SQRT_BITS   = 16;
   localparam int TIME_BITS_D = 16;
   localparam int CSR_ADDR_W  = 2;
   localparam int REQ_DATA_W  = 104;

   localparam logic [RATE_W-1:0] RATE_RESET  = RATE_W'(65536);
   localparam logic [RATE_W-1:0] ACCEL_RESET = RATE_W'(65536);

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_AXIS1_RATE  = 2'd0,
      REG_AXIS2_RATE  = 2'd1,
      REG_AXIS1_ACCEL = 2'd2,
      REG_AXIS2_ACCEL = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [RATE_W-1:0] rate;
      logic [RATE_W-1:0] accel;
   } axis_cfg_type;

endpackage

// ----- rtl/tst_axis.sv -----
// one axis: angle change, profile test, bit-serial square root and division stages
module tst_axis #(
   parameter int D_W       = tst_pkg::AZ_W,
   parameter int TIME_BITS = tst_pkg::TIME_BITS_D
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [D_W-1:0]           pos_from,
   input  logic [D_W-1:0]           pos_to,
   input  tst_pkg::axis_cfg_type    cfg,
   output logic [TIME_BITS-1:0]     n_ff
);

   localparam int R_W    = tst_pkg::RATE_W;
   localparam int SB     = tst_pkg::SQRT_BITS;
   localparam int DA_W   = D_W + R_W;
   localparam int RR_W   = 2 * R_W;
   localparam int NUM_W  = ((DA_W > RR_W) ? DA_W : RR_W) + 1;
   localparam int DEN_W  = 2 * R_W;
   localparam int REM_W  = (NUM_W > DEN_W + TIME_BITS) ? NUM_W : DEN_W + TIME_BITS;
   localparam int SQ_W   = 2 * SB + R_W + 1;
   localparam int NA_W   = SB + R_W;
   localparam int FD_W   = D_W + 2;
   localparam int NSTEP  = (SB > TIME_BITS) ? SB : TIME_BITS;
   localparam int N_W    = ((SB > TIME_BITS) ? SB : TIME_BITS) + 1;

   logic signed [D_W:0] diff_in;
   logic [D_W-1:0]      d_in, d_ff, d2_ff;
   logic [DA_W-1:0]     da_in, da_ff;
   logic [RR_W-1:0]     rr_in, rr_ff;
   logic [DEN_W-1:0]    ar_in, ar_ff;

   logic [SQ_W-1:0]      sq_in  [0:NSTEP];
   logic [SQ_W-1:0]      sq_ff  [0:NSTEP];
   logic [NA_W-1:0]      na_in  [0:NSTEP];
   logic [NA_W-1:0]      na_ff  [0:NSTEP];
   logic [SB-1:0]        m_in   [0:NSTEP];
   logic [SB-1:0]        m_ff   [0:NSTEP];
   logic [FD_W-1:0]      fd_in  [0:NSTEP];
   logic [FD_W-1:0]      fd_ff  [0:NSTEP];
   logic [REM_W-1:0]     rem_in [0:NSTEP];
   logic [REM_W-1:0]     rem_ff [0:NSTEP];
   logic [TIME_BITS-1:0] q_in   [0:NSTEP];
   logic [TIME_BITS-1:0] q_ff   [0:NSTEP];
   logic [DEN_W-1:0]     den_in [0:NSTEP];
   logic [DEN_W-1:0]     den_ff [0:NSTEP];
   logic                 tri_in [0:NSTEP];
   logic                 tri_ff [0:NSTEP];

   logic [N_W-1:0]       tri_n, trap_n, sel_n;
   logic                 sat;
   logic [TIME_BITS-1:0] n_in;

   // angle change
   always_comb begin
      diff_in = $signed({pos_from[D_W-1], pos_from}) - $signed({pos_to[D_W-1], pos_to});
      d_in    = diff_in[D_W] ? D_W'(-diff_in) : diff_in[D_W-1:0];
   end

   // products
   always_comb begin
      da_in = DA_W'(d_ff) * DA_W'(cfg.accel);
      rr_in = RR_W'(cfg.rate) * RR_W'(cfg.rate);
      ar_in = DEN_W'(cfg.accel) * DEN_W'(cfg.rate);
   end

   // profile test and loop setup
   always_comb begin
      sq_in[0]  = '0;
      na_in[0]  = '0;
      m_in[0]   = '0;
      fd_in[0]  = {d2_ff, 2'b00};
      rem_in[0] = REM_W'(NUM_W'(da_ff) + NUM_W'(rr_ff));
      q_in[0]   = '0;
      den_in[0] = ar_ff;
      tri_in[0] = NUM_W'(da_ff) < NUM_W'(rr_ff);
   end

   for (genvar s = 1; s <= NSTEP; s++) begin : g_step
      logic [SQ_W-1:0]  cand;
      logic [REM_W-1:0] dsh;
      if (s <= SB) begin : g_sqrt
         localparam int K = SB - s;
         always_comb begin
            cand = sq_ff[s-1] + (SQ_W'(na_ff[s-1]) << (K + 1))
                 + (SQ_W'(cfg.accel) << (2 * K));
            if (cand < SQ_W'(fd_ff[s-1])) begin
               sq_in[s] = cand;
               na_in[s] = na_ff[s-1] + (NA_W'(cfg.accel) << K);
               m_in[s]  = m_ff[s-1] | (SB'(1) << K);
            end else begin
               sq_in[s] = sq_ff[s-1];
               na_in[s] = na_ff[s-1];
               m_in[s]  = m_ff[s-1];
            end
         end
      end else begin : g_sqrt_pass
         always_comb begin
            cand     = '0;
            sq_in[s] = sq_ff[s-1];
            na_in[s] = na_ff[s-1];
            m_in[s]  = m_ff[s-1];
         end
      end
      if (s <= TIME_BITS) begin : g_div
         localparam int J = TIME_BITS - s;
         always_comb begin
            dsh = REM_W'(den_ff[s-1]) << J;
            if (rem_ff[s-1] >= dsh) begin
               rem_in[s] = rem_ff[s-1] - dsh;
               q_in[s]   = q_ff[s-1] | (TIME_BITS'(1) << J);
            end else begin
               rem_in[s] = rem_ff[s-1];
               q_in[s]   = q_ff[s-1];
            end
         end
      end else begin : g_div_pass
         always_comb begin
            dsh       = '0;
            rem_in[s] = rem_ff[s-1];
            q_in[s]   = q_ff[s-1];
         end
      end
      always_comb begin
         fd_in[s]  = fd_ff[s-1];
         den_in[s] = den_ff[s-1];
         tri_in[s] = tri_ff[s-1];
      end
   end

   // pick the profile and saturate
   always_comb begin
      tri_n  = (fd_ff[NSTEP] == '0) ? '0 : N_W'(m_ff[NSTEP]) + N_W'(1);
      trap_n = N_W'(q_ff[NSTEP]) + N_W'(rem_ff[NSTEP] != '0);
      sat    = (cfg.rate == '0) || (cfg.accel == '0);
      if (tri_ff[NSTEP]) begin
         sel_n = tri_n;
      end else begin
         sel_n = trap_n;
         if (rem_ff[NSTEP] >= REM_W'(den_ff[NSTEP])) sat = 1'b1;
      end
      if (sel_n > N_W'({TIME_BITS{1'b1}})) sat = 1'b1;
      n_in = sat ? {TIME_BITS{1'b1}} : sel_n[TIME_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff  <= d_in;
         d2_ff <= d_ff;
         da_ff <= da_in;
         rr_ff <= rr_in;
         ar_ff <= ar_in;
         for (int i = 0; i <= NSTEP; i++) begin
            sq_ff[i]  <= sq_in[i];
            na_ff[i]  <= na_in[i];
            m_ff[i]   <= m_in[i];
            fd_ff[i]  <= fd_in[i];
            rem_ff[i] <= rem_in[i];
            q_ff[i]   <= q_in[i];
            den_ff[i] <= den_in[i];
            tri_ff[i] <= tri_in[i];
         end
         n_ff <= n_in;
      end
   end

endmodule

// ----- rtl/two_axis_slew_time.sv -----
// top level: two-axis slew time engine with registers, valid pipeline and result register
//
// channel   direction  contents
// req_      in         az_from, az_to, el_from, el_to (two's complement)
// rsp_      out        slew_seconds
// csr_      in         rate and accel registers, write only
//
// one request per cycle while no stalled result holds the pipeline
// the bit-serial square root and division stages give one bit per stage
// reset is synchronous and clears the valid pipeline and loads rate and accel to 1.0
// a stalled result holds the whole pipeline, nothing is dropped or repeated
module two_axis_slew_time #(
   parameter int TIME_BITS = tst_pkg::TIME_BITS_D
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [tst_pkg::REQ_DATA_W-1:0]        req_tdata,  // az_from, az_to, el_from, el_to
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((TIME_BITS+7)/8)*8-1:0]        rsp_tdata,  // slew_seconds
   input  logic                                  csr_we,
   input  logic [tst_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [tst_pkg::RATE_W-1:0]            csr_wdata
);

   localparam int AZ_W  = tst_pkg::AZ_W;
   localparam int EL_W  = tst_pkg::EL_W;
   localparam int SB    = tst_pkg::SQRT_BITS;
   localparam int NSTEP = (SB > TIME_BITS) ? SB : TIME_BITS;
   localparam int LAT   = NSTEP + 5;
   localparam int RSP_W = ((TIME_BITS + 7) / 8) * 8;

   tst_pkg::axis_cfg_type cfg1_ff, cfg2_ff;
   logic                  advance;
   logic [LAT-1:0]        vld_ff;
   logic [TIME_BITS-1:0]  t1, t2, slew_in, slew_ff;

   assign advance    = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = RSP_W'(slew_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg1_ff.rate  <= tst_pkg::RATE_RESET;
         cfg2_ff.rate  <= tst_pkg::RATE_RESET;
         cfg1_ff.accel <= tst_pkg::ACCEL_RESET;
         cfg2_ff.accel <= tst_pkg::ACCEL_RESET;
      end else if (csr_we) begin
         unique case (tst_pkg::csr_idx_type'(csr_addr))
            tst_pkg::REG_AXIS1_RATE:  cfg1_ff.rate  <= csr_wdata;
            tst_pkg::REG_AXIS2_RATE:  cfg2_ff.rate  <= csr_wdata;
            tst_pkg::REG_AXIS1_ACCEL: cfg1_ff.accel <= csr_wdata;
            tst_pkg::REG_AXIS2_ACCEL: cfg2_ff.accel <= csr_wdata;
            default: ;
         endcase
      end
   end

   tst_axis #(.D_W(AZ_W), .TIME_BITS(TIME_BITS)) u_az (
      .clock    (clock),
      .en       (advance),
      .pos_from (req_tdata[AZ_W-1:0]),
      .pos_to   (req_tdata[2*AZ_W-1:AZ_W]),
      .cfg      (cfg1_ff),
      .n_ff     (t1)
   );

   tst_axis #(.D_W(EL_W), .TIME_BITS(TIME_BITS)) u_el (
      .clock    (clock),
      .en       (advance),
      .pos_from (req_tdata[2*AZ_W+EL_W-1:2*AZ_W]),
      .pos_to   (req_tdata[2*AZ_W+2*EL_W-1:2*AZ_W+EL_W]),
      .cfg      (cfg2_ff),
      .n_ff     (t2)
   );

   assign slew_in = (t2 > t1) ? t2 : t1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) slew_ff <= slew_in;
   end

   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff))
      else $error("valid pipeline moved during stall");
   a_shift: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid == $past(vld_ff[LAT-2]))
      else $error("valid pipeline shifted wrongly");

endmodule
